@@ rtl/core/mwmf_pkg.sv @@
// Shared types and constants for the multichannel window median filter.
`timescale 1ns / 1ps
`default_nettype none

package mwmf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CH_W      = 3;
    localparam int MASK_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] FILL_VALUE_RST   = 16'd0;
    localparam logic [MASK_W-1:0]   AVERAGE_MASK_RST = 7'd0;
    localparam logic [MASK_W-1:0]   SIGNED_MASK_RST  = 7'd126;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_REINIT = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILL_VALUE   = 2'd0,
        CFG_AVERAGE_MASK = 2'd1,
        CFG_SIGNED_MASK  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        t_op                 operation;
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [CH_W-1:0]     out_channel;
        logic [SAMPLE_W-1:0] filtered;
    } t_out_beat;

endpackage

`default_nettype wire

@@ rtl/core/mwmf_median.sv @@
// Rank-select median of one window, signed or unsigned order.
`timescale 1ns / 1ps
`default_nettype none

module mwmf_median #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic [mwmf_pkg::SAMPLE_W-1:0] i_win [WINDOW_LEN],
    input  wire logic                          i_signed,
    output logic      [mwmf_pkg::SAMPLE_W-1:0] o_median
);

    localparam int MID = WINDOW_LEN / 2;

    logic [mwmf_pkg::SAMPLE_W-1:0] w_key  [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]         w_below[WINDOW_LEN];
    logic [WINDOW_LEN-1:0]         w_pick;

    // Flip the sign bit so two's complement order becomes unsigned order.
    always_comb begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            w_key[i] = i_win[i] ^ {i_signed, {(mwmf_pkg::SAMPLE_W-1){1'b0}}};
        end
    end

    // Element i ranks above j when j is smaller, or equal and earlier.
    always_comb begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            for (int j = 0; j < WINDOW_LEN; j++) begin
                w_below[i][j] = (j != i) &&
                                ((w_key[j] < w_key[i]) ||
                                 ((w_key[j] == w_key[i]) && (j < i)));
            end
            w_pick[i] = ($countones(w_below[i]) == MID);
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            o_median = o_median | (i_win[i] & {mwmf_pkg::SAMPLE_W{w_pick[i]}});
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/multichannel_window_median_filter.sv @@
// Top level of the multichannel sliding-window median and mean filter.
`timescale 1ns / 1ps
`default_nettype none

// Each channel keeps a circular window of its last WINDOW_LEN samples. A filter
// beat stores its sample at the channel's write position, advances that
// position and returns one result beat: the median of the window, or, for a
// channel whose average_mask bit is set, the window mean truncated toward zero.
// Channels whose signed_mask bit is set order and sum as two's complement;
// channels beyond the mask width always take the unsigned median. A
// reinitialise beat loads fill_value into every slot, clears every position and
// returns nothing; so does a filter beat for a channel that does not exist,
// except that it changes nothing. One beat is accepted every cycle while the
// output is not stalled; a result passes through the three register stages
// (window capture, median select and sum, reciprocal multiply). The pipeline
// keeps taking beats into its free stages while a result waits on the output.
// Reset clears all windows at once; there is no clearing pass.
// Write configuration only while the filter is idle.
module multichannel_window_median_filter #(
    parameter int WINDOW_LEN   = 5,
    parameter int NUM_CHANNELS = 7
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire mwmf_pkg::t_in_beat             i_in_beat,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output mwmf_pkg::t_out_beat                 o_out_beat,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mwmf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mwmf_pkg::SAMPLE_W-1:0]  i_cfg_data
);

    localparam int SW        = mwmf_pkg::SAMPLE_W;
    localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W     = $clog2(WINDOW_LEN);
    // Sum of sign-extended samples, and its magnitude.
    localparam int SUM_W     = SW + 1 + $clog2(WINDOW_LEN);
    localparam int MAG_W     = SUM_W - 1;
    // Exact floor(mag / WINDOW_LEN) by reciprocal for mag below 2**MAG_W.
    localparam int DIV_SHIFT = MAG_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // Configuration registers.
    logic [SW-1:0]               r_fill_value;
    logic [mwmf_pkg::MASK_W-1:0] r_average_mask;
    logic [mwmf_pkg::MASK_W-1:0] r_signed_mask;

    // Window store and write positions.
    logic [SW-1:0]    r_store [NUM_CHANNELS][WINDOW_LEN];
    logic [POS_W-1:0] r_pos   [NUM_CHANNELS];

    // Stage A: captured window with the new sample in place.
    logic                 r_a_valid;
    logic [SW-1:0]        r_a_win [WINDOW_LEN];
    logic [mwmf_pkg::CH_W-1:0] r_a_ch;
    logic                 r_a_signed;
    logic                 r_a_avg;

    // Stage B: median, and sign and magnitude of the sum.
    logic                 r_b_valid;
    logic [mwmf_pkg::CH_W-1:0] r_b_ch;
    logic                 r_b_avg;
    logic                 r_b_neg;
    logic [MAG_W-1:0]     r_b_mag;
    logic [SW-1:0]        r_b_med;

    // Stage C: output register.
    logic                 r_c_valid;
    mwmf_pkg::t_out_beat  r_c_beat;

    logic                 w_c_load;
    logic                 w_b_load;
    logic                 w_a_load;
    logic                 w_accept;
    logic                 w_in_range;
    logic                 w_filter;
    logic                 w_reinit;
    logic [CH_IDX_W-1:0]  w_ch_idx;
    logic [POS_W-1:0]     w_pos;
    logic [POS_W-1:0]     n_pos;
    logic [SW-1:0]        w_row [WINDOW_LEN];
    logic                 w_has_mask;
    logic                 w_signed;
    logic                 w_avg;
    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-1:0]     w_abs;
    logic                 w_neg;
    logic [SW-1:0]        w_med;
    logic [PROD_W-1:0]    w_prod;
    logic [SW-1:0]        w_quot;
    logic [SW-1:0]        w_mean;

    // Handshake: each stage loads when it is empty or its contents move on.
    assign w_c_load   = !r_c_valid || i_out_ready;
    assign w_b_load   = !r_b_valid || w_c_load;
    assign w_a_load   = !r_a_valid || w_b_load;
    assign o_in_ready = w_a_load;
    assign w_accept   = i_in_valid && w_a_load;
    assign o_cfg_ready = 1'b1;

    assign w_in_range = (32'(i_in_beat.channel) < NUM_CHANNELS);
    assign w_reinit   = w_accept && (i_in_beat.operation == mwmf_pkg::OP_REINIT);
    assign w_filter   = w_accept && (i_in_beat.operation == mwmf_pkg::OP_FILTER)
                        && w_in_range;
    assign w_ch_idx   = CH_IDX_W'(i_in_beat.channel);

    // Read the channel's row and drop the new sample into its write slot.
    always_comb begin
        w_pos = w_in_range ? r_pos[w_ch_idx] : '0;
        n_pos = (w_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : w_pos + 1'b1;
        for (int s = 0; s < WINDOW_LEN; s++) begin
            if (POS_W'(s) == w_pos) begin
                w_row[s] = i_in_beat.sample;
            end else if (w_in_range) begin
                w_row[s] = r_store[w_ch_idx][s];
            end else begin
                w_row[s] = '0;
            end
        end
    end

    // Channels past the mask width have no bit and stay unsigned median.
    always_comb begin
        w_has_mask = (i_in_beat.channel < mwmf_pkg::MASK_W);
        w_signed   = w_has_mask ? r_signed_mask[i_in_beat.channel]  : 1'b0;
        w_avg      = w_has_mask ? r_average_mask[i_in_beat.channel] : 1'b0;
    end

    // Configuration writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_value   <= mwmf_pkg::FILL_VALUE_RST;
            r_average_mask <= mwmf_pkg::AVERAGE_MASK_RST;
            r_signed_mask  <= mwmf_pkg::SIGNED_MASK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mwmf_pkg::CFG_FILL_VALUE: begin
                    r_fill_value <= i_cfg_data;
                end
                mwmf_pkg::CFG_AVERAGE_MASK: begin
                    r_average_mask <= i_cfg_data[mwmf_pkg::MASK_W-1:0];
                end
                mwmf_pkg::CFG_SIGNED_MASK: begin
                    r_signed_mask <= i_cfg_data[mwmf_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Window store: clear on reset, refill on reinitialise, write one slot on a filter beat for an existing channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pos[c] <= '0;
                for (int s = 0; s < WINDOW_LEN; s++) begin
                    r_store[c][s] <= '0;
                end
            end
        end else if (w_reinit) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pos[c] <= '0;
                for (int s = 0; s < WINDOW_LEN; s++) begin
                    r_store[c][s] <= r_fill_value;
                end
            end
        end else if (w_filter) begin
            r_store[w_ch_idx][w_pos] <= i_in_beat.sample;
            r_pos[w_ch_idx]          <= n_pos;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_a_load) begin
                r_a_valid <= w_filter;
            end
            if (w_b_load) begin
                r_b_valid <= r_a_valid;
            end
            if (w_c_load) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Stage B logic: sum of the window, extended per the channel's order.
    always_comb begin
        w_sum = '0;
        for (int s = 0; s < WINDOW_LEN; s++) begin
            w_sum = w_sum + {{(SUM_W - SW){r_a_signed & r_a_win[s][SW-1]}}, r_a_win[s]};
        end
        w_neg = r_a_signed & w_sum[SUM_W-1];
        w_abs = w_neg ? (~w_sum + 1'b1) : w_sum;
    end

    mwmf_median #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_median (
        .i_win    (r_a_win),
        .i_signed (r_a_signed),
        .o_median (w_med)
    );

    // Stage C logic: divide the magnitude by the window length, restore sign.
    always_comb begin
        w_prod = PROD_W'(r_b_mag) * PROD_W'(RECIP);
        w_quot = w_prod[DIV_SHIFT +: SW];
        w_mean = r_b_neg ? (~w_quot + 1'b1) : w_quot;
    end

    // Payload registers advance with their valid bits.
    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_win    <= w_row;
            r_a_ch     <= i_in_beat.channel;
            r_a_signed <= w_signed;
            r_a_avg    <= w_avg;
        end
        if (w_b_load) begin
            r_b_ch  <= r_a_ch;
            r_b_avg <= r_a_avg;
            r_b_neg <= w_neg;
            r_b_mag <= w_abs[MAG_W-1:0];
            r_b_med <= w_med;
        end
        if (w_c_load) begin
            r_c_beat.out_channel <= r_b_ch;
            r_c_beat.filtered    <= r_b_avg ? w_mean : r_b_med;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_beat  = r_c_beat;

endmodule

`default_nettype wire

@@ rtl/core/mwmf_checker.sv @@
// Port-level assertions for the filter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module mwmf_checker #(
    parameter int NUM_CHANNELS = 7
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire mwmf_pkg::t_out_beat o_out_beat
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    // With the output free or draining, the pipeline must take a beat.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output side can move");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("result beat changed while stalled");

    // Only existing channels produce results.
    a_out_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_beat.out_channel) < NUM_CHANNELS))
        else $error("result for a channel that does not exist");

endmodule

bind multichannel_window_median_filter mwmf_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_mwmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire

@@ tb/sv/tb_multichannel_window_median_filter.sv @@
// Self-checking testbench for the multichannel window median filter.
`timescale 1ns / 1ps

module tb_multichannel_window_median_filter;

    import mwmf_pkg::*;

    // Block geometry as instantiated; the predictor is built to the same sizes.
    localparam int NCH  = 7;
    localparam int WLEN = 5;

    // Let the pipeline drain before touching configuration, since reinitialise
    // and absent-channel beats leave nothing behind to wait for.
    localparam int SETTLE_CYCLES = 6;
    localparam int HANG_LIMIT    = 4000;
    localparam int NUM_PHASES    = 8;
    localparam int RANDOM_BEATS  = 1750;
    localparam int DIR_ROWS      = 24;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_ALTERNATE} stall_mode_e;

    // One line of the directed stimulus: either a beat or a register write.
    // Where typed is set, exp_filt replaces the predicted value.
    typedef struct packed {
        row_kind_e           kind;
        t_op                 op;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        t_cfg_reg            reg_idx;
        logic [SAMPLE_W-1:0] cfg_data;
        logic                typed;
        logic [SAMPLE_W-1:0] exp_filt;
    } dir_row_t;

    // Opens from the reset state: all windows zero, channels 1-6 two's complement.
    dir_row_t dir_rows [DIR_ROWS] = '{
        // unsigned channel, largest pattern, then the most negative signed value
        '{ROW_BEAT, OP_FILTER, 3'd0, 16'hFFFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd1, 16'h8000, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h0000},
        // channel that does not exist: no result, no state change
        '{ROW_BEAT, OP_FILTER, 3'd7, 16'h1234, CFG_FILL_VALUE,   16'h0000, 1'b0, 16'h0000},
        // majority of the window flips the median
        '{ROW_BEAT, OP_FILTER, 3'd0, 16'hFFFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd0, 16'hFFFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'hFFFF},
        '{ROW_BEAT, OP_FILTER, 3'd1, 16'h8000, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd1, 16'h8000, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h8000},
        '{ROW_BEAT, OP_FILTER, 3'd2, 16'h7FFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd2, 16'h7FFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd2, 16'h7FFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h7FFF},
        // reinitialise with junk in the channel and sample fields
        '{ROW_BEAT, OP_REINIT, 3'd7, 16'hFFFF, CFG_FILL_VALUE,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd0, 16'h0001, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'h0000},
        // everything signed and averaged, windows filled with all ones
        '{ROW_CFG,  OP_FILTER, 3'd0, 16'h0000, CFG_FILL_VALUE,   16'hFFFF, 1'b0, 16'h0000},
        '{ROW_CFG,  OP_FILTER, 3'd0, 16'h0000, CFG_AVERAGE_MASK, 16'h007F, 1'b0, 16'h0000},
        '{ROW_CFG,  OP_FILTER, 3'd0, 16'h0000, CFG_SIGNED_MASK,  16'h007F, 1'b0, 16'h0000},
        '{ROW_BEAT, OP_REINIT, 3'd0, 16'h0000, CFG_FILL_VALUE,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd0, 16'hFFFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'hFFFF},
        // negative mean that must truncate toward zero
        '{ROW_BEAT, OP_FILTER, 3'd3, 16'h8000, CFG_FILL_VALUE,   16'h0000, 1'b0, 16'h0000},
        // unsigned averages: large sum, and the largest possible mean
        '{ROW_CFG,  OP_FILTER, 3'd0, 16'h0000, CFG_SIGNED_MASK,  16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd4, 16'h0000, CFG_FILL_VALUE,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd5, 16'hFFFF, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'hFFFF},
        '{ROW_CFG,  OP_FILTER, 3'd0, 16'h0000, CFG_AVERAGE_MASK, 16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, OP_FILTER, 3'd6, 16'h0000, CFG_FILL_VALUE,   16'h0000, 1'b1, 16'hFFFF},
        '{ROW_BEAT, OP_FILTER, 3'd7, 16'h5A5A, CFG_FILL_VALUE,   16'h0000, 1'b0, 16'h0000}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_beat            in_beat = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_beat           out_beat;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0] cfg_data = '0;

    // Predictor state: per-channel windows, write slots and register copies.
    logic [SAMPLE_W-1:0] chan_window [NCH][WLEN];
    int                  chan_slot [NCH];
    logic [SAMPLE_W-1:0] fill_reg;
    logic [MASK_W-1:0]   mean_sel;
    logic [MASK_W-1:0]   twos_sel;

    // Results predicted but not yet seen on the output, oldest first.
    t_out_beat filtered_due [$];

    int errors = 0;
    int n_beats = 0;
    int n_reinit = 0;
    int n_absent = 0;
    int n_mean = 0;
    int n_median = 0;
    int n_checked = 0;
    int n_cfg = 0;
    int idle_cycles = 0;

    stall_mode_e ready_mode = STALL_NONE;
    int          ready_left = 0;
    logic        ready_toggle = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multichannel_window_median_filter #(
        .WINDOW_LEN   (WLEN),
        .NUM_CHANNELS (NCH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] due,
                                   input logic [SAMPLE_W-1:0] seen);
        if (errors < 100)
            $display("%0t: mismatch on %s: due %h, seen %h", $realtime, what, due, seen);
        errors++;
    endtask

    // Advance the predictor by one accepted beat; return 1 with the result
    // where the beat yields one.
    function automatic bit filter_step(input t_in_beat b, output t_out_beat r);
        int                  c;
        int                  s;
        int                  lt;
        int                  le;
        int signed           acc;
        logic [SAMPLE_W-1:0] flip;
        logic [SAMPLE_W-1:0] keys [WLEN];
        logic [SAMPLE_W-1:0] mid;

        r = '0;
        if (b.operation == OP_REINIT) begin
            for (c = 0; c < NCH; c++) begin
                for (s = 0; s < WLEN; s++)
                    chan_window[c][s] = fill_reg;
                chan_slot[c] = 0;
            end
            n_reinit++;
            return 1'b0;
        end
        c = int'(b.channel);
        if (c >= NCH) begin
            n_absent++;
            return 1'b0;
        end

        // Store at the write slot and move it on, wrapping at the window end.
        s = chan_slot[c];
        chan_window[c][s] = b.sample;
        chan_slot[c] = (s == WLEN - 1) ? 0 : s + 1;

        r.out_channel = b.channel;
        if (mean_sel[c]) begin
            acc = 0;
            for (s = 0; s < WLEN; s++)
                acc += twos_sel[c] ? int'($signed(chan_window[c][s])) : int'(chan_window[c][s]);
            // Integer division truncates toward zero for negative sums too.
            acc = acc / WLEN;
            r.filtered = acc[SAMPLE_W-1:0];
            n_mean++;
        end else begin
            // Flip the sign bit so that two's complement orders as unsigned,
            // then pick the key whose rank spans the middle position.
            flip = twos_sel[c] ? 16'h8000 : 16'h0000;
            for (s = 0; s < WLEN; s++)
                keys[s] = chan_window[c][s] ^ flip;
            mid = keys[0];
            for (int i = 0; i < WLEN; i++) begin
                lt = 0;
                le = 0;
                for (int j = 0; j < WLEN; j++) begin
                    if (keys[j] < keys[i])
                        lt++;
                    if (keys[j] <= keys[i])
                        le++;
                end
                if (lt <= WLEN / 2 && WLEN / 2 < le)
                    mid = keys[i];
            end
            r.filtered = mid ^ flip;
            n_median++;
        end
        return 1'b1;
    endfunction

    // Mostly filter beats on live channels; a few reinitialise and absent-channel
    // beats. Samples lean on the extremes and on small values either side of
    // zero so that ties and sign crossings turn up often.
    function automatic t_in_beat gen_beat();
        t_in_beat b;
        int       pick;
        int       flavour;

        pick = $urandom_range(0, 99);
        b.operation = (pick < 2) ? OP_REINIT : OP_FILTER;
        b.channel = (pick >= 2 && pick < 7) ? 3'd7 : CH_W'($urandom_range(0, 7 - 1));
        if (b.operation == OP_REINIT)
            b.channel = CH_W'($urandom);
        flavour = $urandom_range(0, 9);
        case (flavour)
            0: begin
                case ($urandom_range(0, 3))
                    0: b.sample = 16'h0000;
                    1: b.sample = 16'hFFFF;
                    2: b.sample = 16'h7FFF;
                    default: b.sample = 16'h8000;
                endcase
            end
            1, 2, 3: b.sample = SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
            default: b.sample = SAMPLE_W'($urandom);
        endcase
        return b;
    endfunction

    // All driving tasks start and finish just after a falling edge.
    task automatic drive_beat(input t_in_beat b, input logic typed,
                              input logic [SAMPLE_W-1:0] typed_filt);
        t_out_beat r;

        in_beat = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Beat taken at this edge: predict now so ordering with configuration holds.
        if (filter_step(b, r)) begin
            if (typed)
                r.filtered = typed_filt;
            filtered_due.push_back(r);
        end
        n_beats++;
        @(negedge clk);
    endtask

    task automatic rest_sender(input int cycles);
        in_valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Hold the sender until every due result has left, then let the pipeline
    // drain of beats that produce nothing.
    task automatic settle_idle();
        in_valid = 1'b0;
        while (filtered_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [SAMPLE_W-1:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FILL_VALUE:   fill_reg = data;
            CFG_AVERAGE_MASK: mean_sel = data[MASK_W-1:0];
            CFG_SIGNED_MASK:  twos_sel = data[MASK_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: stretches of random length, each with its own stall pattern,
    // from always ready to mostly stalled.
    always @(negedge clk) begin
        if (ready_left == 0) begin
            ready_mode = stall_mode_e'($urandom_range(0, 3));
            ready_left = $urandom_range(4, 60);
        end
        ready_left--;
        ready_toggle = ~ready_toggle;
        case (ready_mode)
            STALL_NONE:  out_ready = 1'b1;
            STALL_HALF:  out_ready = 1'($urandom_range(0, 1));
            STALL_HEAVY: out_ready = ($urandom_range(0, 3) == 0);
            default:     out_ready = ready_toggle;
        endcase
    end

    // Check every result beat against the oldest one due.
    always @(posedge clk) begin
        t_out_beat due;
        if (rst_n && out_valid && out_ready) begin
            if (filtered_due.size() == 0) begin
                report_mismatch("result with nothing due", 16'h0000, out_beat.filtered);
            end else begin
                due = filtered_due.pop_front();
                if (out_beat.out_channel !== due.out_channel)
                    report_mismatch("out_channel", 16'(due.out_channel),
                                    16'(out_beat.out_channel));
                if (out_beat.filtered !== due.filtered)
                    report_mismatch("filtered", due.filtered, out_beat.filtered);
                n_checked++;
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == HANG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results still due",
                         $realtime, HANG_LIMIT, filtered_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_in_beat            b;
        int                  burst;
        int                  done;
        int                  phase_goal;
        logic                halted;
        logic [SAMPLE_W-1:0] fv;
        logic [SAMPLE_W-1:0] am;
        logic [SAMPLE_W-1:0] sm;

        // Predictor starts from the reset state of the block.
        for (int c = 0; c < NCH; c++) begin
            for (int s = 0; s < WLEN; s++)
                chan_window[c][s] = '0;
            chan_slot[c] = 0;
        end
        fill_reg = FILL_VALUE_RST;
        mean_sel = AVERAGE_MASK_RST;
        twos_sel = SIGNED_MASK_RST;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: walk the table, writing registers only when idle.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].cfg_data);
            end else begin
                b.operation = dir_rows[i].op;
                b.channel = dir_rows[i].ch;
                b.sample = dir_rows[i].smp;
                drive_beat(b, dir_rows[i].typed, dir_rows[i].exp_filt);
                if ($urandom_range(0, 2) == 0)
                    rest_sender($urandom_range(1, 3));
            end
        end

        // Random part: several configuration phases, extremes first.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_idle();
            case (ph)
                0: begin
                    fv = 16'h0000; am = 16'h0000; sm = 16'h007E;
                end
                1: begin
                    // upper data bits set: only the mask width must take effect
                    fv = 16'hFFFF; am = 16'hFFFF; sm = 16'hFFFF;
                end
                2: begin
                    fv = 16'h8000; am = 16'h007F; sm = 16'h0000;
                end
                3: begin
                    fv = 16'h7FFF; am = 16'h0000; sm = 16'h007F;
                end
                default: begin
                    fv = SAMPLE_W'($urandom);
                    am = SAMPLE_W'($urandom);
                    sm = SAMPLE_W'($urandom);
                end
            endcase
            write_reg(CFG_FILL_VALUE, fv);
            write_reg(CFG_AVERAGE_MASK, am);
            write_reg(CFG_SIGNED_MASK, sm);

            phase_goal = RANDOM_BEATS / NUM_PHASES;
            done = 0;
            halted = 1'b0;
            while (done < phase_goal) begin
                burst = $urandom_range(1, 24);
                repeat (burst) begin
                    b = gen_beat();
                    drive_beat(b, 1'b0, 16'h0000);
                    // beats for an absent channel are ignored: do not count them
                    if (!(b.operation == OP_FILTER && int'(b.channel) >= NCH))
                        done++;
                end
                if (!halted && done >= phase_goal / 2) begin
                    // Pause mid-phase until the output side has caught up.
                    halted = 1'b1;
                    settle_idle();
                end else if ($urandom_range(0, 9) < 7) begin
                    rest_sender($urandom_range(1, 10));
                end
            end
        end

        // Drain, then go on waiting for any stray result before reporting.
        settle_idle();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d beats: %0d results checked (%0d mean, %0d median),",
                 n_beats, n_checked, n_mean, n_median);
        $display("%0d reinitialise, %0d absent-channel beats, %0d register writes, %0d errors",
                 n_reinit, n_absent, n_cfg, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mwmf_pkg.sv
rtl/core/mwmf_median.sv
rtl/core/multichannel_window_median_filter.sv
rtl/core/mwmf_checker.sv
tb/sv/tb_multichannel_window_median_filter.sv
